### rtl/core/cubic_bezier_point_evaluator_macros.svh
// assertion macros for the cubic bezier point evaluator
// used by the top level; relies on a clock and an active-low reset passed in
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CBPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbpe check failed in same cycle");

// antecedent implies consequent in the following cycle
`define CBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbpe check failed one cycle later");

`endif

### rtl/core/cbpe_pkg.sv
// shared widths, types, register indexes and lerp functions
// for the cubic bezier point evaluator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbpe_pkg;

  localparam int COORD_BITS  = 11;
  localparam int T_FRAC_BITS = 10;
  localparam int NUM_PTS     = 4;
  localparam int CFG_IDX_W   = 4;

  // value widths after each interpolation level (exact numerators)
  localparam int T_W  = T_FRAC_BITS + 1;
  localparam int L1_W = COORD_BITS + T_FRAC_BITS;
  localparam int L2_W = L1_W + T_FRAC_BITS;
  localparam int ROUND_SHIFT = 3 * T_FRAC_BITS;

  // accumulator widths for a*s + b*t at each level
  localparam int S1_W = COORD_BITS + T_W + 1;
  localparam int S2_W = L1_W + T_W + 1;
  localparam int S3_W = L2_W + T_W + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [T_W-1:0]        tval_t;
  typedef logic [L1_W-1:0]       lvl1_t;
  typedef logic [L2_W-1:0]       lvl2_t;

  localparam tval_t T_ONE = tval_t'(1) << T_FRAC_BITS;
  localparam logic [S3_W-1:0] ROUND_HALF = S3_W'(1) << (ROUND_SHIFT - 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_P0_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_P0_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_P1_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_P1_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_P2_X = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_P2_Y = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_P3_X = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_P3_Y = CFG_IDX_W'(7);

  // control points, one coordinate of all four points per member
  typedef struct packed {
    coord_t [NUM_PTS-1:0] x;
    coord_t [NUM_PTS-1:0] y;
  } ctrl_pts_t;

  // curve parameter and its complement, traveling with a valid bit
  typedef struct packed {
    logic  valid;
    tval_t t;
    tval_t s;
  } tstep_t;

  // first level: coordinates to numerator over 2^F
  function automatic lvl1_t lerp_l1(coord_t a, coord_t b, tval_t s, tval_t t);
    logic [S1_W-1:0] acc;
    acc = S1_W'(a) * S1_W'(s) + S1_W'(b) * S1_W'(t);
    return acc[L1_W-1:0];
  endfunction

  // second level: numerator over 2^2F
  function automatic lvl2_t lerp_l2(lvl1_t a, lvl1_t b, tval_t s, tval_t t);
    logic [S2_W-1:0] acc;
    acc = S2_W'(a) * S2_W'(s) + S2_W'(b) * S2_W'(t);
    return acc[L2_W-1:0];
  endfunction

  // last level plus round half up and scale back to a coordinate
  function automatic coord_t lerp_round(lvl2_t a, lvl2_t b, tval_t s, tval_t t);
    logic [S3_W-1:0] acc;
    acc = S3_W'(a) * S3_W'(s) + S3_W'(b) * S3_W'(t) + ROUND_HALF;
    return acc[ROUND_SHIFT +: COORD_BITS];
  endfunction

endpackage

`default_nettype wire

### rtl/core/cubic_bezier_point_evaluator.sv
// a request accepted at an edge is taken by the input register and then passes
// through the three stages of each axis pipeline before out_valid strobes for it
// throughput: one request per clock; busy stays low, the pipeline never stalls
// rate is set by the three registered lerp multiplier stages of each axis pipeline
// reset clears all control points to zero and drops every request in flight
// top level of the cubic bezier point evaluator; depends on cbpe_pkg, cbpe_cfg_regs,
// cbpe_axis_pipe and cubic_bezier_point_evaluator_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_bezier_point_evaluator_macros.svh"

module cubic_bezier_point_evaluator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cbpe_pkg::tval_t                 in_t_code,
  output logic                                 out_valid,
  output cbpe_pkg::coord_t                     out_curve_x,
  output cbpe_pkg::coord_t                     out_curve_y,
  input  wire logic                            cfg_we,
  input  wire logic [cbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire cbpe_pkg::coord_t                cfg_data
);

  cbpe_pkg::ctrl_pts_t pts;
  cbpe_pkg::tstep_t    step_r;
  cbpe_pkg::tval_t     t_sat;
  logic                accept;
  logic                x_valid;
  logic                y_valid;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // control point registers
  cbpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pts       (pts)
  );

  // clamp t to one
  assign t_sat = (in_t_code > cbpe_pkg::T_ONE) ? cbpe_pkg::T_ONE : in_t_code;

  // input stage: register t and 1 - t, valid cleared on reset
  always_ff @(posedge clk) begin
    step_r.t <= t_sat;
    step_r.s <= cbpe_pkg::T_ONE - t_sat;
    if (!rst_n) begin
      step_r.valid <= 1'b0;
    end else begin
      step_r.valid <= accept;
    end
  end

  // one pipeline per axis
  cbpe_axis_pipe u_pipe_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_in   (step_r),
    .pts       (pts.x),
    .res_valid (x_valid),
    .res_coord (out_curve_x)
  );

  cbpe_axis_pipe u_pipe_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_in   (step_r),
    .pts       (pts.y),
    .res_valid (y_valid),
    .res_coord (out_curve_y)
  );

  assign out_valid = x_valid;

  // checks
  `CBPE_ASSERT_SAME(a_lanes_aligned, clk, rst_n, 1'b1, x_valid == y_valid)
  `CBPE_ASSERT_SAME(a_weights_sum_one, clk, rst_n, step_r.valid, (step_r.t + step_r.s) == cbpe_pkg::T_ONE)
  `CBPE_ASSERT_SAME(a_result_has_request, clk, rst_n, out_valid, $past(accept, 4))
  `CBPE_ASSERT_NEXT(a_request_enters, clk, rst_n, accept, step_r.valid)

endmodule

`default_nettype wire

### rtl/core/cbpe_cfg_regs.sv
// control point register file written through the configuration port
// depends on cbpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpe_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cbpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire cbpe_pkg::coord_t                 cfg_data,
  output cbpe_pkg::ctrl_pts_t                   pts
);

  cbpe_pkg::ctrl_pts_t pts_r;
  cbpe_pkg::ctrl_pts_t pts_nxt;

  // decode the write; unknown indexes are dropped
  always_comb begin
    pts_nxt = pts_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cbpe_pkg::REG_P0_X: pts_nxt.x[0] = cfg_data;
        cbpe_pkg::REG_P0_Y: pts_nxt.y[0] = cfg_data;
        cbpe_pkg::REG_P1_X: pts_nxt.x[1] = cfg_data;
        cbpe_pkg::REG_P1_Y: pts_nxt.y[1] = cfg_data;
        cbpe_pkg::REG_P2_X: pts_nxt.x[2] = cfg_data;
        cbpe_pkg::REG_P2_Y: pts_nxt.y[2] = cfg_data;
        cbpe_pkg::REG_P3_X: pts_nxt.x[3] = cfg_data;
        cbpe_pkg::REG_P3_Y: pts_nxt.y[3] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else begin
      pts_r <= pts_nxt;
    end
  end

  assign pts = pts_r;

endmodule

`default_nettype wire

### rtl/core/cbpe_axis_pipe.sv
// three-stage de casteljau pipeline for one coordinate axis
// depends on cbpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpe_axis_pipe (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire cbpe_pkg::tstep_t                          step_in,
  input  wire cbpe_pkg::coord_t [cbpe_pkg::NUM_PTS-1:0]  pts,
  output logic                                           res_valid,
  output cbpe_pkg::coord_t                               res_coord
);

  cbpe_pkg::tstep_t step1_r;
  cbpe_pkg::tstep_t step2_r;
  cbpe_pkg::lvl1_t  q1_r   [3];
  cbpe_pkg::lvl1_t  q1_nxt [3];
  cbpe_pkg::lvl2_t  q2_r   [2];
  cbpe_pkg::lvl2_t  q2_nxt [2];
  cbpe_pkg::coord_t coord_r;
  cbpe_pkg::coord_t coord_nxt;
  logic             valid_r;

  // level one: three lerps between neighboring control points
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q1_nxt[i] = cbpe_pkg::lerp_l1(pts[i], pts[i+1], step_in.s, step_in.t);
    end
  end

  // level two: two lerps between level one results
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q2_nxt[i] = cbpe_pkg::lerp_l2(q1_r[i], q1_r[i+1], step1_r.s, step1_r.t);
    end
  end

  // level three with rounding to the output coordinate
  assign coord_nxt = cbpe_pkg::lerp_round(q2_r[0], q2_r[1], step2_r.s, step2_r.t);

  // payload registers, valid bits cleared on reset
  always_ff @(posedge clk) begin
    q1_r    <= q1_nxt;
    q2_r    <= q2_nxt;
    coord_r <= coord_nxt;
    step1_r.t <= step_in.t;
    step1_r.s <= step_in.s;
    step2_r.t <= step1_r.t;
    step2_r.s <= step1_r.s;
    if (!rst_n) begin
      step1_r.valid <= 1'b0;
      step2_r.valid <= 1'b0;
      valid_r       <= 1'b0;
    end else begin
      step1_r.valid <= step_in.valid;
      step2_r.valid <= step1_r.valid;
      valid_r       <= step2_r.valid;
    end
  end

  assign res_valid = valid_r;
  assign res_coord = coord_r;

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for cubic_bezier_point_evaluator: random and directed
// curve parameters under several control point settings, scored against a local predictor
// depends on cbpe_pkg and the cubic_bezier_point_evaluator rtl
`timescale 1ns / 1ps

module testbench;

  localparam int PIPE_DEPTH = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_REGS = 2 * cbpe_pkg::NUM_PTS;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 128;

  // point setting kinds used between phases
  typedef enum int {PTS_ALL_MAX, PTS_ALL_ZERO, PTS_CORNERS, PTS_RANDOM} pts_kind_t;

  typedef struct {
    cbpe_pkg::tval_t  t_code;
    cbpe_pkg::coord_t x;
    cbpe_pkg::coord_t y;
  } curve_point_t;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  cbpe_pkg::tval_t  in_t_code = '0;
  logic   cfg_we = 1'b0;
  logic [cbpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  cbpe_pkg::coord_t cfg_data = '0;
  logic   busy;
  logic   out_valid;
  cbpe_pkg::coord_t out_curve_x;
  cbpe_pkg::coord_t out_curve_y;

  // local copy of the control points, as the block holds them
  cbpe_pkg::coord_t pt_x [cbpe_pkg::NUM_PTS];
  cbpe_pkg::coord_t pt_y [cbpe_pkg::NUM_PTS];

  cbpe_pkg::tval_t pending_t_codes [$];
  curve_point_t    expected_points [$];
  int  sender_idle_pct = 0;
  bit  pause_for_drain = 1'b0;
  int  drain_pauses = 0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  requests_sent = 0;
  int  settings_used = 1;
  int  cycle_count = 0;

  logic [cbpe_pkg::CFG_IDX_W-1:0] reg_order [NUM_REGS] = '{
    cbpe_pkg::REG_P0_X, cbpe_pkg::REG_P0_Y, cbpe_pkg::REG_P1_X, cbpe_pkg::REG_P1_Y,
    cbpe_pkg::REG_P2_X, cbpe_pkg::REG_P2_Y, cbpe_pkg::REG_P3_X, cbpe_pkg::REG_P3_Y};

  cubic_bezier_point_evaluator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_t_code   (in_t_code),
    .out_valid   (out_valid),
    .out_curve_x (out_curve_x),
    .out_curve_y (out_curve_y),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // exact bernstein sum over 2^(3F), rounded half up
  function automatic cbpe_pkg::coord_t bezier_axis(
      cbpe_pkg::coord_t p0, cbpe_pkg::coord_t p1, cbpe_pkg::coord_t p2,
      cbpe_pkg::coord_t p3, cbpe_pkg::tval_t t_code);
    longint unsigned t;
    longint unsigned s;
    longint unsigned num;
    t = (t_code > cbpe_pkg::T_ONE) ? cbpe_pkg::T_ONE : t_code;
    s = cbpe_pkg::T_ONE - t;
    num = s * s * s * p0 + 3 * s * s * t * p1 + 3 * s * t * t * p2 + t * t * t * p3;
    num += 64'd1 << (cbpe_pkg::ROUND_SHIFT - 1);
    return cbpe_pkg::coord_t'(num >> cbpe_pkg::ROUND_SHIFT);
  endfunction

  function automatic curve_point_t predict_point(cbpe_pkg::tval_t t_code);
    curve_point_t p;
    p.t_code = t_code;
    p.x = bezier_axis(pt_x[0], pt_x[1], pt_x[2], pt_x[3], t_code);
    p.y = bezier_axis(pt_y[0], pt_y[1], pt_y[2], pt_y[3], t_code);
    return p;
  endfunction

  // mostly in range, some edges, some above one
  function automatic cbpe_pkg::tval_t random_t_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      case ($urandom_range(3))
        0: return '0;
        1: return cbpe_pkg::tval_t'(1);
        2: return cbpe_pkg::T_ONE - 1;
        default: return cbpe_pkg::T_ONE;
      endcase
    end else if (pick < 22) begin
      return cbpe_pkg::tval_t'($urandom_range((1 << cbpe_pkg::T_W) - 1));
    end
    return cbpe_pkg::tval_t'($urandom_range(cbpe_pkg::T_ONE));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // one register write, local copy follows known indexes only
  task automatic write_reg(input logic [cbpe_pkg::CFG_IDX_W-1:0] idx,
                           input cbpe_pkg::coord_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      cbpe_pkg::REG_P0_X: pt_x[0] = value;
      cbpe_pkg::REG_P0_Y: pt_y[0] = value;
      cbpe_pkg::REG_P1_X: pt_x[1] = value;
      cbpe_pkg::REG_P1_Y: pt_y[1] = value;
      cbpe_pkg::REG_P2_X: pt_x[2] = value;
      cbpe_pkg::REG_P2_Y: pt_y[2] = value;
      cbpe_pkg::REG_P3_X: pt_x[3] = value;
      cbpe_pkg::REG_P3_Y: pt_y[3] = value;
      default: ;
    endcase
  endtask

  // program all four points, plus a write to an unused index
  task automatic program_points(input pts_kind_t kind);
    cbpe_pkg::coord_t value;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (kind)
        PTS_ALL_MAX:  value = '1;
        PTS_ALL_ZERO: value = '0;
        PTS_CORNERS:  value = $urandom_range(1) ? '1 : '0;
        default:      value = cbpe_pkg::coord_t'($urandom);
      endcase
      write_reg(reg_order[i], value);
    end
    write_reg(cbpe_pkg::CFG_IDX_W'($urandom_range((1 << cbpe_pkg::CFG_IDX_W) - 1, NUM_REGS)),
              cbpe_pkg::coord_t'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_t_codes.size() != 0 || expected_points.size() != 0 || start)
      @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("cubic_bezier_point_evaluator regression: fail");
      $finish;
    end
  end

  // request driver, fed from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(predict_point(in_t_code));
        requests_sent++;
      end
      // now and then hold off until every result is back
      if (pause_for_drain && expected_points.size() == 0) begin
        pause_for_drain = 1'b0;
      end else if (!pause_for_drain && expected_points.size() != 0 &&
                   $urandom_range(99) == 0) begin
        pause_for_drain = 1'b1;
        drain_pauses++;
      end
      if (!(start && busy)) begin
        if (pending_t_codes.size() != 0 && !pause_for_drain &&
            $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          in_t_code <= pending_t_codes.pop_front();
        end else begin
          start <= 1'b0;
          in_t_code <= cbpe_pkg::tval_t'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d", out_curve_x, out_curve_y));
      end else begin
        exp_pt = expected_points.pop_front();
        results_checked++;
        if (out_curve_x !== exp_pt.x)
          report_mismatch($sformatf("t_code=%0d curve_x=%0d, predicted %0d",
                                    exp_pt.t_code, out_curve_x, exp_pt.x));
        if (out_curve_y !== exp_pt.y)
          report_mismatch($sformatf("t_code=%0d curve_y=%0d, predicted %0d",
                                    exp_pt.t_code, out_curve_y, exp_pt.y));
      end
    end
  end

  // stimulus sequence
  initial begin
    cbpe_pkg::tval_t zero_pts_t [6];
    cbpe_pkg::tval_t edge_t [16];
    zero_pts_t = '{0, 512, 1024, 2047, 1, 1023};
    edge_t = '{0, 1, 2, 511, 512, 513, 1023, 1024, 1025, 1536, 2047, 341, 682, 256, 768,
               1000};
    for (int i = 0; i < cbpe_pkg::NUM_PTS; i++) begin
      pt_x[i] = '0;
      pt_y[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset points, then corner points (p1 and p2 on the same corner)
    foreach (zero_pts_t[i]) pending_t_codes.push_back(zero_pts_t[i]);
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_order[i], (i == 0 || i == 3 || i == 5 || i == 6) ? '0 : '1);
    write_reg(cbpe_pkg::CFG_IDX_W'(NUM_REGS), '1);
    write_reg('1, cbpe_pkg::coord_t'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    settings_used++;
    foreach (edge_t[i]) pending_t_codes.push_back(edge_t[i]);
    wait_drained();

    // random phases across point settings and sender idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: program_points((ph == 0) ? PTS_ALL_MAX : PTS_ALL_ZERO);
        2: program_points(PTS_CORNERS);
        default: program_points(PTS_RANDOM);
      endcase
      case (ph % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 76;
        default: sender_idle_pct = 13;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_t_codes.push_back(random_t_code());
      wait_drained();
    end

    if (expected_points.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_points.size()));
    $display("covered %0d requests and %0d checked results over %0d point settings",
             requests_sent, results_checked, settings_used);
    $display("including t above one, unused register writes and %0d drain pauses",
             drain_pauses);
    if (mismatch_count == 0) begin
      $display("cubic_bezier_point_evaluator regression: pass");
    end else begin
      $display("cubic_bezier_point_evaluator regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cbpe_pkg.sv
rtl/core/cbpe_cfg_regs.sv
rtl/core/cbpe_axis_pipe.sv
rtl/core/cubic_bezier_point_evaluator.sv
dv/testbench.sv
